FILE: sv/histogram_percentile_macros.svh
// Assertion macros shared by the histogram percentile RTL.
`ifndef HISTOGRAM_PERCENTILE_MACROS_SVH
`define HISTOGRAM_PERCENTILE_MACROS_SVH

`ifndef SYNTHESIS
`define HP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("histogram_percentile: assertion failed");
`define HP_ASSERT_NEVER(lbl, cond) `HP_ASSERT(lbl, !(cond))
`else
`define HP_ASSERT(lbl, prop)
`define HP_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: sv/hp_pkg.sv
// Types and constants of the histogram percentile engine.
package hp_pkg;

	localparam int VAL_W = 16;
	localparam int CNT_W = 32;
	localparam int FRAC_W = 17;
	localparam int TGT_W = 33;
	localparam int PROD_W = FRAC_W + CNT_W;
	localparam int OUT_W = 32;
	localparam int IDXO_W = 8;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_MIN   = 2'd0,
		REG_MAX   = 2'd1,
		REG_DELTA = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SPAN,
		ST_OFF,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_MUL,
		ST_WALK,
		ST_EDGE
	} state_t;

	typedef struct packed {
		logic             go;
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

endpackage

FILE: sv/hp_div.sv
// Restoring divider, one quotient bit per cycle, shared by the bin index paths.
module hp_div import hp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [VAL_W-1:0] quotient
);

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  dsr_q;
	logic [VAL_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(VAL_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			// shift in next dividend bit, subtract when the divisor fits
			rem_q <= fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/histogram_percentile.sv
// Histogram percentile engine: add, clear and percentile query over 16-bit samples.
// Add: two 16-step divisions, then a count update, before returning to idle.
// Query: a span division, a target multiply and a bin walk, then the done strobe; the walk reads one count per cycle.
// Clear: one memory entry zeroed per cycle over all NUM_BINS entries; no result.
// Reset: asynchronous, sets control and configuration registers to defaults, then a clear sweep
// over all NUM_BINS entries holds busy high. done pulses for one cycle and the receiver cannot stall it.
module histogram_percentile import hp_pkg::*; #(
	parameter int NUM_BINS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic signed [VAL_W-1:0] sample_value,
	input  logic [FRAC_W-1:0]       fraction,
	output logic                    done,
	output logic                    found,
	output logic signed [OUT_W-1:0] bin_value,
	output logic [IDXO_W-1:0]       bin_index
);

`include "histogram_percentile_macros.svh"

	localparam int IDX_W = $clog2(NUM_BINS);
	localparam int LAST_MAX = NUM_BINS - 1;
	localparam int SUM_W = TGT_W + IDX_W;
	localparam int EDGE_W = VAL_W + IDX_W;

	state_t state_q, state_d;

	logic signed [VAL_W-1:0] min_q;
	logic signed [VAL_W-1:0] max_q;
	logic [VAL_W-1:0]        delta_q;
	logic [VAL_W-1:0]        delta_eff;
	logic                    cfg_wr;

	req_t                    req_q;
	logic signed [VAL_W-1:0] sample_q;
	logic [FRAC_W-1:0]       frac_q;

	logic [CNT_W-1:0]  mem [NUM_BINS];
	logic              mem_we;
	logic [CNT_W-1:0]  mem_wdata;
	logic [CNT_W-1:0]  rdata_q;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  last_q;
	logic [CNT_W-1:0]  total_q;

	logic              issued_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_nxt;
	logic              hit;
	logic [TGT_W-1:0]  target_q;
	logic [PROD_W-1:0] tgt_prod;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [EDGE_W-1:0] edge_prod;

	logic                    done_q;
	logic                    found_q;
	logic signed [OUT_W-1:0] bin_value_q;
	logic [IDXO_W-1:0]       bin_index_q;

	div_req_t          div_req;
	logic              div_done;
	logic [VAL_W-1:0]  div_quo;
	logic [VAL_W:0]    span;
	logic [VAL_W:0]    offset;
	logic [IDX_W-1:0]  span_last;
	logic [IDX_W-1:0]  off_idx;

	hp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= VAL_W'(255);
			delta_q <= VAL_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_MIN:   min_q   <= pwdata[VAL_W-1:0];
				REG_MAX:   max_q   <= pwdata[VAL_W-1:0];
				REG_DELTA: delta_q <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_MIN:   prdata = {16'd0, min_q};
			REG_MAX:   prdata = {16'd0, max_q};
			REG_DELTA: prdata = {16'd0, delta_q};
			default:   prdata = '0;
		endcase
	end

	// bin arithmetic
	assign delta_eff = (delta_q == '0) ? VAL_W'(1) : delta_q;
	assign span      = {max_q[VAL_W-1], max_q} - {min_q[VAL_W-1], min_q};
	assign offset    = {sample_q[VAL_W-1], sample_q} - {min_q[VAL_W-1], min_q};
	assign span_last = (div_quo > VAL_W'(LAST_MAX)) ? IDX_W'(LAST_MAX) : div_quo[IDX_W-1:0];
	assign off_idx   = (div_quo > VAL_W'(last_q)) ? last_q : div_quo[IDX_W-1:0];
	assign tgt_prod  = PROD_W'(frac_q) * PROD_W'(total_q);
	assign edge_prod = EDGE_W'(delta_eff) * EDGE_W'(hit_idx_q);
	assign sum_nxt   = sum_q + SUM_W'(rdata_q);
	assign hit       = sum_nxt >= SUM_W'(target_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (addr_q == IDX_W'(LAST_MAX))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (req_t'(req_type))
						REQ_ADD, REQ_QUERY: state_d = ST_SPAN;
						REQ_CLEAR:          state_d = ST_CLR;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_SPAN: begin
				if (div_done)
					state_d = (req_q == REQ_ADD) ? ST_OFF : ST_MUL;
			end
			ST_OFF: begin
				if (div_done)
					state_d = ST_ADD_RD;
			end
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_IDLE;
			ST_MUL: begin
				state_d = (total_q == '0) ? ST_IDLE : ST_WALK;
			end
			ST_WALK: begin
				if (rd_vld_s1 && hit)
					state_d = ST_EDGE;
				else if (rd_vld_s1 && rd_idx_s1 == last_q)
					state_d = ST_IDLE;
			end
			ST_EDGE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = 1'b1;
		div_req   = '0;
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (req_t'(req_type) == REQ_ADD || req_t'(req_type) == REQ_QUERY)) begin
					// negative span leaves one bin: a zero dividend gives that
					div_req.go       = 1'b1;
					div_req.dividend = span[VAL_W] ? '0 : span[VAL_W-1:0];
					div_req.divisor  = delta_eff;
				end
			end
			ST_SPAN: begin
				if (div_done && req_q == REQ_ADD) begin
					div_req.go       = 1'b1;
					div_req.dividend = offset[VAL_W] ? '0 : offset[VAL_W-1:0];
					div_req.divisor  = delta_eff;
				end
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			addr_q    <= '0;
			total_q   <= '0;
			issued_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				ST_CLR: begin
					addr_q  <= addr_q + 1'b1;
					total_q <= '0;
				end
				ST_IDLE: begin
					addr_q <= '0;
				end
				ST_OFF: begin
					if (div_done)
						addr_q <= off_idx;
				end
				ST_ADD_WR: begin
					if (total_q != '1)
						total_q <= total_q + 1'b1;
				end
				ST_MUL: begin
					addr_q   <= '0;
					issued_q <= 1'b0;
					if (total_q == '0)
						done_q <= 1'b1;
				end
				ST_WALK: begin
					// issue one read per cycle up to the last bin in use
					rd_vld_s1 <= !issued_q && state_d == ST_WALK;
					if (!issued_q) begin
						if (addr_q == last_q)
							issued_q <= 1'b1;
						else
							addr_q <= addr_q + 1'b1;
					end
					if (state_d == ST_IDLE)
						done_q <= 1'b1;
				end
				ST_EDGE: begin
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q    <= req_t'(req_type);
					sample_q <= sample_value;
					frac_q   <= fraction;
				end
			end
			ST_SPAN: begin
				if (div_done)
					last_q <= span_last;
			end
			ST_MUL: begin
				target_q    <= tgt_prod[PROD_W-1:16];
				sum_q       <= '0;
				found_q     <= 1'b0;
				bin_value_q <= '0;
				bin_index_q <= '0;
			end
			ST_WALK: begin
				if (rd_vld_s1) begin
					sum_q <= sum_nxt;
					if (hit)
						hit_idx_q <= rd_idx_s1;
				end
			end
			ST_EDGE: begin
				found_q     <= 1'b1;
				bin_value_q <= OUT_W'(min_q) + OUT_W'(edge_prod);
				bin_index_q <= IDXO_W'(hit_idx_q);
			end
			default: ;
		endcase
	end

	// count memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr_q] <= mem_wdata;
		rdata_q <= mem[addr_q];
	end

	assign done      = done_q;
	assign found     = found_q;
	assign bin_value = bin_value_q;
	assign bin_index = bin_index_q;

	`HP_ASSERT(a_done_query, done |-> req_q == REQ_QUERY)
	`HP_ASSERT_NEVER(a_done_busy, done && busy)
	`HP_ASSERT(a_walk_addr, state_q == ST_WALK |-> addr_q <= last_q)
	`HP_ASSERT(a_div_state, div_done |-> state_q == ST_SPAN || state_q == ST_OFF)
	`HP_ASSERT(a_miss_zero, done && !found |-> bin_value == '0 && bin_index == '0)

endmodule
